/* rtl/dsl_codec_pkg.sv */
package dsl_codec_pkg;

  // character codes
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // article length counter
  localparam int unsigned LENGTH_BITS = 26;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // item command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // conversion direction
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   last_of_run;
    logic                   article_end;
    logic [LENGTH_BITS-1:0] out_length;
  } out_item_t;

  // decode lookahead window, entry 0 is the oldest byte
  typedef logic [2:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] used;
    logic       line_start;
  } dec_step_t;

  // one decode step on the head of the window (fill is nonzero)
  function automatic dec_step_t dec_step(input win_t w, input logic [1:0] fill,
                                         input logic ls);
    dec_step_t s;
    logic two;
    two = (fill >= 2'd2);
    if (ls && two && w[0] == CH_DOT && w[1] == CH_DOT) begin
      s.out_byte   = CH_DOT;
      s.used       = 2'd2;
      s.line_start = 1'b0;
    end else if (two && w[0] == CH_CR && w[1] == CH_LF) begin
      s.out_byte   = CH_LF;
      s.used       = 2'd2;
      s.line_start = 1'b1;
    end else begin
      s.out_byte   = w[0];
      s.used       = 2'd1;
      s.line_start = 1'b0;
    end
    return s;
  endfunction

  // drop one or two bytes from the front of the window
  function automatic win_t win_shift(input win_t w, input logic [1:0] k);
    win_t r;
    r = w;
    if (k == 2'd1) begin
      r[0] = w[1];
      r[1] = w[2];
    end else if (k == 2'd2) begin
      r[0] = w[2];
    end
    return r;
  endfunction

endpackage

/* rtl/dot_stuffing_line_codec.sv */
// Dot-stuffing line codec: converts an article byte stream between native
// form (LF line ends) and wire form (CR LF line ends, leading dots doubled,
// closed by dot CR LF). The direction register picks encode (0) or decode (1).
// Input channel item_valid/item_ready/item carries one byte (cmd 0) or the
// end of an article (cmd 1). Output channel result_valid/result_ready/result
// carries one output byte per item, marked last_of_run on the last one that
// an input item causes; the end of an article carries article_end and the
// saturating output byte count in out_length.
// Config channel cfg_valid/cfg_ready/cfg_direction is always ready; a write
// sets the direction and restarts the article. Write it only while idle.
// The first result of an input item is registered and shows in the cycle
// after accept. Each input item is converted in one pass and its up to three
// results go into a small result buffer drained one per cycle while the
// receiver takes them. The next item is taken in the cycle that the last
// result leaves.
// Reset (synchronous, rst high) selects encode, empties the buffer and
// starts a new article. While the receiver stalls, the result holds.
module dot_stuffing_line_codec
  import dsl_codec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_direction
);

  // article state
  dir_t                   direction;
  logic                   line_start;
  win_t                   win;
  logic [1:0]             fill;
  logic [1:0]             seen;
  logic [LENGTH_BITS-1:0] len_count;

  // result buffer, entry 0 is at the output
  out_item_t              res [3];
  logic [1:0]             res_cnt;

  // combinational results of the accepted item
  out_item_t              new_res [3];
  logic [1:0]             n_new;
  logic                   line_start_next;
  win_t                   win_next;
  logic [1:0]             fill_next;
  logic [1:0]             seen_next;
  logic [LENGTH_BITS-1:0] len_count_next;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS-1:0] len_sat;

  logic accept;
  logic pop;

  assign cfg_ready    = 1'b1;
  assign result_valid = (res_cnt != 2'd0);
  assign result       = res[0];
  assign pop          = result_valid && result_ready;
  assign item_ready   = (res_cnt == 2'd0) || (res_cnt == 2'd1 && result_ready);
  assign accept       = item_valid && item_ready;

  // conversion of one item
  always_comb begin
    win_t       wv;
    logic [1:0] fv;
    logic       lsv;
    dec_step_t  st;
    logic [1:0] after;
    logic       bare;
    logic [1:0] n_valid;

    for (int i = 0; i < 3; i++) begin
      new_res[i] = '0;
    end
    n_new           = 2'd0;
    line_start_next = line_start;
    win_next        = win;
    fill_next       = fill;
    seen_next       = seen;
    bare            = 1'b0;
    wv              = win;
    fv              = fill;
    lsv             = line_start;
    st              = '0;
    after           = 2'd0;

    if (item.cmd == CMD_BYTE) begin
      if (direction == DIR_ENCODE) begin
        // LF becomes CR LF, a leading dot is doubled
        if (item.data == CH_LF) begin
          new_res[0].out_byte = CH_CR;
          new_res[1].out_byte = CH_LF;
          n_new               = 2'd2;
          line_start_next     = 1'b1;
        end else if (line_start && item.data == CH_DOT) begin
          new_res[0].out_byte = CH_DOT;
          new_res[1].out_byte = CH_DOT;
          n_new               = 2'd2;
          line_start_next     = 1'b0;
        end else begin
          new_res[0].out_byte = item.data;
          n_new               = 2'd1;
          line_start_next     = 1'b0;
        end
      end else begin
        // full window: emit one decoded byte, then append the new one
        if (fill == 2'd3) begin
          st                  = dec_step(win, fill, line_start);
          new_res[0].out_byte = st.out_byte;
          n_new               = 2'd1;
          line_start_next     = st.line_start;
          win_next            = win_shift(win, st.used);
          after               = 2'd3 - st.used;
          win_next[after]     = item.data;
          fill_next           = after + 2'd1;
        end else begin
          win_next[fill] = item.data;
          fill_next      = fill + 2'd1;
        end
        if (seen != 2'd3) begin
          seen_next = seen + 2'd1;
        end
      end
    end else begin
      if (direction == DIR_ENCODE) begin
        // closing dot CR LF
        new_res[0].out_byte = CH_DOT;
        new_res[1].out_byte = CH_CR;
        new_res[2].out_byte = CH_LF;
        n_new               = 2'd3;
      end else if (seen != 2'd3) begin
        // short article passes through verbatim
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < fill) begin
            new_res[i].out_byte = win[i];
          end
        end
        n_new = fill;
      end else if (!(fill == 2'd3 && win[0] == CH_DOT && win[1] == CH_CR
                     && win[2] == CH_LF)) begin
        // flush the window through the decoder
        for (int i = 0; i < 3; i++) begin
          if (fv != 2'd0) begin
            st                  = dec_step(wv, fv, lsv);
            new_res[i].out_byte = st.out_byte;
            n_new               = 2'(i + 1);
            wv                  = win_shift(wv, st.used);
            fv                  = fv - st.used;
            lsv                 = st.line_start;
          end
        end
      end
      // article restarts
      line_start_next = 1'b1;
      fill_next       = 2'd0;
      seen_next       = 2'd0;
      if (n_new == 2'd0) begin
        bare  = 1'b1;
        n_new = 2'd1;
      end
    end

    // saturating length count
    n_valid = bare ? 2'd0 : n_new;
    len_sum = {1'b0, len_count} + (LENGTH_BITS + 1)'(n_valid);
    len_sat = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
    len_count_next = (item.cmd == CMD_END) ? '0 : len_sat;

    // byte valid and run and article markers
    for (int i = 0; i < 3; i++) begin
      new_res[i].byte_valid = (2'(i) < n_valid);
      if (2'(i) == 2'(n_new - 2'd1) && n_new != 2'd0) begin
        new_res[i].last_of_run = 1'b1;
        if (item.cmd == CMD_END) begin
          new_res[i].article_end = 1'b1;
          new_res[i].out_length  = len_sat;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_ENCODE;
      line_start <= 1'b1;
      fill       <= 2'd0;
      seen       <= 2'd0;
      len_count  <= '0;
      res_cnt    <= 2'd0;
    end else begin
      if (cfg_valid) begin
        direction  <= dir_t'(cfg_direction);
        line_start <= 1'b1;
        fill       <= 2'd0;
        seen       <= 2'd0;
        len_count  <= '0;
      end else if (accept) begin
        line_start <= line_start_next;
        fill       <= fill_next;
        seen       <= seen_next;
        len_count  <= len_count_next;
      end
      if (accept) begin
        res_cnt <= n_new;
      end else if (pop) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  // window and result buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
      for (int i = 0; i < 3; i++) begin
        res[i] <= new_res[i];
      end
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule
